FILE: rtl/mft_pkg.sv
`default_nettype none

package mft_pkg;

    // block configuration
    localparam int MOTOR_SLOTS         = 4;
    localparam int ENC_COUNTS_PER_TURN = 5119;

    // id registers and slots that can match
    localparam int ID_REGS     = 4;
    localparam int MATCH_SLOTS = (MOTOR_SLOTS < ID_REGS) ? MOTOR_SLOTS : ID_REGS;
    localparam int SLOT_W      = (MATCH_SLOTS > 1) ? $clog2(MATCH_SLOTS) : 1;

    // port widths
    localparam int ID_W        = 11;
    localparam int PAYLOAD_W   = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int TARGET_W    = 3;
    localparam int TOTAL_W     = 32;
    localparam int ROUND_W     = 16;
    localparam int ANGLE_NOW_W = 17;
    localparam int TWICE_W     = 17;
    localparam int CUR_W       = 16;
    localparam int START_W     = 16;
    localparam int TURNS_W     = 20;
    localparam int SPD_W       = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_D = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENCODER = 3'd4;

    localparam logic [ID_W-1:0] MOTOR_ID_RESET [ID_REGS] = '{11'd513, 11'd514, 11'd515, 11'd516};
    localparam logic [ID_W-1:0] ENC_ID_RESET = 11'd0;

    // target codes besides the slot numbers
    localparam logic [TARGET_W-1:0] TGT_ENCODER = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_NONE    = 3'd5;

    // motor frame words
    localparam int ANGLE_W    = 16;
    localparam int WRAP_LIMIT = 4096;
    localparam int TURN_SHIFT = 13;
    localparam int TURN_COUNTS = 8192;

    // encoder path
    localparam int DIV_W     = 32;
    localparam int REM_W     = $clog2(ENC_COUNTS_PER_TURN);
    localparam int SCALE_W   = 13;
    localparam int ABS_W     = 13;
    localparam int ENC_ANG_W = ABS_W + 1;
    localparam int DIFF_W    = ABS_W + 3;
    localparam int STEP_W    = DIFF_W + 1;
    localparam int SPEED_K_W = 10;
    localparam logic [SCALE_W-1:0]   SCALE_COUNTS = 13'd8191;
    localparam logic [SPEED_K_W-1:0] SPEED_Q16    = 10'd918;
    localparam logic [DIV_W-1:0]     DIV_CONST    = DIV_W'(ENC_COUNTS_PER_TURN);
    localparam logic [DIV_W-1:0]     DIV_RECIP    =
        DIV_W'((64'd1 << DIV_W) / ENC_COUNTS_PER_TURN);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [ANGLE_W-1:0]  angle;
        logic [ANGLE_W-1:0]  speed;
        logic [ANGLE_W-1:0]  current;
        logic [DIV_W-1:0]    enc_count;
    } t_item;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } t_div_result;

endpackage

`default_nettype wire

FILE: rtl/motor_feedback_multiturn_tracker.sv
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_frame_id, i_payload
// out       from block o_out_valid / i_out_ready o_target .. o_angular_speed_q16
// cfg       to block   i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
// a frame transfer is taken every cycle while the two-entry queue has room
// motor and no-match frames pass from the queue head into the output register;
// encoder frames run the constant divider twice in series, then wait in ST_FINISH
// reset is synchronous: ids go to their defaults, all tracking state to zero
// a stalled output holds its register; the back end then stops popping, bar one
// encoder frame held in ST_FINISH, and the queue fills before o_in_ready drops
`default_nettype none

module motor_feedback_multiturn_tracker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration writes
    input  wire logic                                  i_cfg_we,
    input  wire logic [mft_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [mft_pkg::ID_W-1:0]              i_cfg_data,
    // received frames
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [mft_pkg::ID_W-1:0]              i_frame_id,
    input  wire logic [mft_pkg::PAYLOAD_W-1:0]         i_payload,
    // tracking results
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [mft_pkg::TARGET_W-1:0]               o_target,
    output logic signed [mft_pkg::TOTAL_W-1:0]         o_total_angle,
    output logic signed [mft_pkg::ROUND_W-1:0]         o_round_count,
    output logic signed [mft_pkg::ANGLE_NOW_W-1:0]     o_angle_now,
    output logic signed [mft_pkg::TWICE_W-1:0]         o_speed_twice_avg,
    output logic signed [mft_pkg::CUR_W-1:0]           o_motor_current,
    output logic [mft_pkg::START_W-1:0]                o_start_angle,
    output logic signed [mft_pkg::TURNS_W-1:0]         o_encoder_raw_turns,
    output logic [mft_pkg::SPD_W-1:0]                  o_angular_speed_q16
);
    import mft_pkg::*;

    t_item            front_item;
    t_item            head_item;
    logic             push;
    logic             head_valid;
    logic             pop;
    logic             div_start;
    logic [DIV_W-1:0] div_dividend;
    t_div_result      div_result;

    // front: id registers, id match and field unpack
    mft_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_frame_id  (i_frame_id),
        .i_payload   (i_payload),
        .o_item      (front_item)
    );

    // a frame transfer pushes the classified item
    assign push = i_in_valid && o_in_ready;

    // short queue so front and back stall independently
    mft_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (o_in_ready),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_item  (head_item)
    );

    // shared divider for turn split and angle rescale
    mft_cdiv u_cdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .o_result   (div_result)
    );

    // back: slot and encoder tracking, output register
    mft_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_head_valid        (head_valid),
        .i_head              (head_item),
        .o_pop               (pop),
        .o_div_start         (div_start),
        .o_div_dividend      (div_dividend),
        .i_div               (div_result),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_target            (o_target),
        .o_total_angle       (o_total_angle),
        .o_round_count       (o_round_count),
        .o_angle_now         (o_angle_now),
        .o_speed_twice_avg   (o_speed_twice_avg),
        .o_motor_current     (o_motor_current),
        .o_start_angle       (o_start_angle),
        .o_encoder_raw_turns (o_encoder_raw_turns),
        .o_angular_speed_q16 (o_angular_speed_q16)
    );

endmodule

`default_nettype wire

FILE: rtl/mft_front.sv
`default_nettype none

module mft_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [mft_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [mft_pkg::ID_W-1:0]      i_cfg_data,
    input  wire logic [mft_pkg::ID_W-1:0]      i_frame_id,
    input  wire logic [mft_pkg::PAYLOAD_W-1:0] i_payload,
    output mft_pkg::t_item                     o_item
);
    import mft_pkg::*;

    logic [ID_W-1:0]     r_motor_id [ID_REGS];
    logic [ID_W-1:0]     r_enc_id;
    logic [TARGET_W-1:0] match_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ID_REGS; i++) begin
                r_motor_id[i] <= MOTOR_ID_RESET[i];
            end
            r_enc_id <= ENC_ID_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOTOR_A: r_motor_id[0] <= i_cfg_data;
                CFG_MOTOR_B: r_motor_id[1] <= i_cfg_data;
                CFG_MOTOR_C: r_motor_id[2] <= i_cfg_data;
                CFG_MOTOR_D: r_motor_id[3] <= i_cfg_data;
                CFG_ENCODER: r_enc_id      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lowest matching slot wins, any slot beats the encoder
    always_comb begin
        match_target = TGT_NONE;
        if (i_frame_id == r_enc_id) begin
            match_target = TGT_ENCODER;
        end
        for (int i = MATCH_SLOTS - 1; i >= 0; i--) begin
            if (r_motor_id[i] == i_frame_id) begin
                match_target = TARGET_W'(i);
            end
        end
    end

    assign o_item.target = match_target;

    // big-endian motor words, little-endian encoder count in bytes 3..6
    assign o_item.angle     = i_payload[63:48];
    assign o_item.speed     = i_payload[47:32];
    assign o_item.current   = i_payload[31:16];
    assign o_item.enc_count = {i_payload[15:8], i_payload[23:16],
                               i_payload[31:24], i_payload[39:32]};

endmodule

`default_nettype wire

FILE: rtl/mft_queue.sv
`default_nettype none

module mft_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire mft_pkg::t_item i_item,
    output logic         o_ready,
    input  wire logic    i_pop,
    output logic         o_valid,
    output mft_pkg::t_item o_item
);
    import mft_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/mft_cdiv.sv
`default_nettype none

// divide by the encoder counts per turn: reciprocal multiply, back-multiply,
// one correction step; one operation in flight
module mft_cdiv (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mft_pkg::DIV_W-1:0] i_dividend,
    output mft_pkg::t_div_result           o_result
);
    import mft_pkg::*;

    logic                   r_s1_vld;
    logic                   r_s2_vld;
    logic                   r_done;
    logic [DIV_W-1:0]       r_x;
    logic [2*DIV_W-1:0]     r_prod;
    logic [DIV_W-1:0]       r_qe;
    logic [DIV_W-1:0]       r_qd;
    logic [DIV_W-1:0]       r_q;
    logic [REM_W-1:0]       r_r;
    logic [DIV_W-1:0]       qe;
    logic [2*DIV_W-1:0]     qd_full;
    logic [DIV_W-1:0]       rem_est;
    logic                   corr;

    assign qe      = r_prod[2*DIV_W-1:DIV_W];
    assign qd_full = (2*DIV_W)'(qe) * (2*DIV_W)'(DIV_CONST);
    assign rem_est = r_x - r_qd;
    assign corr    = (rem_est >= DIV_CONST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
            r_s2_vld <= r_s1_vld;
            r_done   <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_dividend;
            r_prod <= (2*DIV_W)'(i_dividend) * (2*DIV_W)'(DIV_RECIP);
        end
        if (r_s1_vld) begin
            r_qe <= qe;
            r_qd <= qd_full[DIV_W-1:0];
        end
        if (r_s2_vld) begin
            r_q <= corr ? r_qe + 1'b1 : r_qe;
            r_r <= REM_W'(corr ? rem_est - DIV_CONST : rem_est);
        end
    end

    assign o_result.done      = r_done;
    assign o_result.quotient  = r_q;
    assign o_result.remainder = r_r;

`ifndef SYNTH
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (DIV_W'(r_r) < DIV_CONST))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire

FILE: rtl/mft_back.sv
`default_nettype none

module mft_back (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_head_valid,
    input  wire mft_pkg::t_item                        i_head,
    output logic                                       o_pop,
    output logic                                       o_div_start,
    output logic [mft_pkg::DIV_W-1:0]                  o_div_dividend,
    input  wire mft_pkg::t_div_result                  i_div,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [mft_pkg::TARGET_W-1:0]               o_target,
    output logic signed [mft_pkg::TOTAL_W-1:0]         o_total_angle,
    output logic signed [mft_pkg::ROUND_W-1:0]         o_round_count,
    output logic signed [mft_pkg::ANGLE_NOW_W-1:0]     o_angle_now,
    output logic signed [mft_pkg::TWICE_W-1:0]         o_speed_twice_avg,
    output logic signed [mft_pkg::CUR_W-1:0]           o_motor_current,
    output logic [mft_pkg::START_W-1:0]                o_start_angle,
    output logic signed [mft_pkg::TURNS_W-1:0]         o_encoder_raw_turns,
    output logic [mft_pkg::SPD_W-1:0]                  o_angular_speed_q16
);
    import mft_pkg::*;

    localparam int SCALED_W = REM_W + SCALE_W;
    localparam int SPROD_W  = DIFF_W + SPEED_K_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_TURNS,
        ST_SCALE,
        ST_DIV_ANGLE,
        ST_FINISH
    } t_state;

    t_state r_state;

    // per-slot tracking state
    logic [ANGLE_W-1:0] r_slot_angle   [MATCH_SLOTS];
    logic [ANGLE_W-1:0] r_slot_speed   [MATCH_SLOTS];
    logic [ROUND_W-1:0] r_slot_rounds  [MATCH_SLOTS];
    logic [START_W-1:0] r_slot_start   [MATCH_SLOTS];
    logic               r_slot_started [MATCH_SLOTS];

    // encoder tracking state
    logic signed [ENC_ANG_W-1:0] r_enc_last;
    logic [TOTAL_W-1:0]          r_enc_total;
    logic [ROUND_W-1:0]          r_enc_rounds;

    // encoder working registers
    logic [DIV_W-1:0] r_dividend;
    logic             r_neg;
    logic [DIV_W-1:0] r_turns;
    logic [ABS_W-1:0] r_abs;

    // output register
    logic                   r_out_valid;
    logic [TARGET_W-1:0]    r_out_target;
    logic [TOTAL_W-1:0]     r_out_total;
    logic [ROUND_W-1:0]     r_out_rounds;
    logic [ANGLE_NOW_W-1:0] r_out_angle;
    logic [TWICE_W-1:0]     r_out_twice;
    logic [CUR_W-1:0]       r_out_current;
    logic [START_W-1:0]     r_out_start;
    logic [TURNS_W-1:0]     r_out_turns;
    logic [SPD_W-1:0]       r_out_speed;

    logic                     out_free;
    logic                     out_load;
    logic                     head_enc;
    logic                     head_none;
    logic [SLOT_W-1:0]        slot;
    logic signed [ANGLE_W:0]  m_diff;
    logic [ROUND_W-1:0]       m_rounds;
    logic [TOTAL_W-1:0]       m_total;
    logic signed [TWICE_W-1:0] m_twice;
    logic [START_W-1:0]       m_start;
    logic [DIV_W-1:0]         h_neg;
    logic [DIV_W-1:0]         h_mag;
    logic [DIV_W-1:0]         scaled;
    logic signed [ENC_ANG_W-1:0] e_ang;
    logic signed [DIFF_W-1:0] e_diff;
    logic [DIFF_W-1:0]        e_mag;
    logic signed [STEP_W-1:0] e_step;
    logic [ROUND_W-1:0]       e_rounds;
    logic [TOTAL_W-1:0]       e_total;
    logic [SPROD_W-1:0]       e_sprod;
    logic [DIV_W-1:0]         e_turns;

    assign out_free  = !r_out_valid || i_out_ready;
    assign head_enc  = (i_head.target == TGT_ENCODER);
    assign head_none = (i_head.target == TGT_NONE);
    assign slot      = i_head.target[SLOT_W-1:0];
    assign o_pop     = (r_state == ST_IDLE) && i_head_valid && (head_enc || out_free);
    // the output register takes a new result
    assign out_load  = (o_pop && !head_enc) || ((r_state == ST_FINISH) && out_free);

    // motor frame: wrap detect on the raw angle step
    always_comb begin
        m_diff = $signed({1'b0, i_head.angle}) - $signed({1'b0, r_slot_angle[slot]});
        if (m_diff > WRAP_LIMIT) begin
            m_rounds = r_slot_rounds[slot] - 1'b1;
        end else if (m_diff < -WRAP_LIMIT) begin
            m_rounds = r_slot_rounds[slot] + 1'b1;
        end else begin
            m_rounds = r_slot_rounds[slot];
        end
        m_total = (TOTAL_W'($signed(m_rounds)) << TURN_SHIFT) + TOTAL_W'(i_head.angle);
        m_twice = TWICE_W'($signed(i_head.speed)) + TWICE_W'($signed(r_slot_speed[slot]));
        m_start = r_slot_started[slot] ? r_slot_start[slot] : i_head.angle;
    end

    // encoder count negated; divide its magnitude, sign applied afterwards
    assign h_neg = DIV_W'(0) - i_head.enc_count;
    assign h_mag = h_neg[DIV_W-1] ? i_head.enc_count : h_neg;

    assign scaled = DIV_W'(SCALED_W'(i_div.remainder) * SCALED_W'(SCALE_COUNTS));

    assign o_div_start    = (r_state == ST_LOAD) || (r_state == ST_SCALE);
    assign o_div_dividend = r_dividend;

    // encoder finish: accumulate total with wrap correction, form speed and turns
    always_comb begin
        e_ang  = r_neg ? -$signed({1'b0, r_abs}) : $signed({1'b0, r_abs});
        e_diff = DIFF_W'(e_ang) - DIFF_W'(r_enc_last);
        e_mag  = (e_diff < 0) ? DIFF_W'(-e_diff) : DIFF_W'(e_diff);
        e_step = STEP_W'(e_diff);
        e_rounds = r_enc_rounds;
        if (e_diff > WRAP_LIMIT) begin
            e_rounds = r_enc_rounds - 1'b1;
            e_step   = STEP_W'(e_diff) - STEP_W'(TURN_COUNTS);
        end else if (e_diff < -WRAP_LIMIT) begin
            e_rounds = r_enc_rounds + 1'b1;
            e_step   = STEP_W'(e_diff) + STEP_W'(TURN_COUNTS);
        end
        e_total = r_enc_total + TOTAL_W'(e_step);
        e_sprod = SPROD_W'(e_mag) * SPROD_W'(SPEED_Q16);
        e_turns = r_neg ? DIV_W'(0) - r_turns : r_turns;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MATCH_SLOTS; i++) begin
                r_slot_angle[i]   <= '0;
                r_slot_speed[i]   <= '0;
                r_slot_rounds[i]  <= '0;
                r_slot_start[i]   <= '0;
                r_slot_started[i] <= 1'b0;
            end
            r_enc_last   <= '0;
            r_enc_total  <= '0;
            r_enc_rounds <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop && head_enc) begin
                        r_dividend <= h_mag;
                        r_neg      <= h_neg[DIV_W-1];
                        r_state    <= ST_LOAD;
                    end else if (o_pop) begin
                        r_out_target  <= i_head.target;
                        r_out_turns   <= '0;
                        r_out_speed   <= '0;
                        if (head_none) begin
                            r_out_total   <= '0;
                            r_out_rounds  <= '0;
                            r_out_angle   <= '0;
                            r_out_twice   <= '0;
                            r_out_current <= '0;
                            r_out_start   <= '0;
                        end else begin
                            r_slot_angle[slot]   <= i_head.angle;
                            r_slot_speed[slot]   <= i_head.speed;
                            r_slot_rounds[slot]  <= m_rounds;
                            r_slot_start[slot]   <= m_start;
                            r_slot_started[slot] <= 1'b1;
                            r_out_total   <= m_total;
                            r_out_rounds  <= m_rounds;
                            r_out_angle   <= ANGLE_NOW_W'(i_head.angle);
                            r_out_twice   <= m_twice;
                            r_out_current <= i_head.current;
                            r_out_start   <= m_start;
                        end
                    end
                end
                ST_LOAD: begin
                    r_state <= ST_DIV_TURNS;
                end
                ST_DIV_TURNS: begin
                    if (i_div.done) begin
                        r_turns    <= i_div.quotient;
                        r_dividend <= scaled;
                        r_state    <= ST_SCALE;
                    end
                end
                ST_SCALE: begin
                    r_state <= ST_DIV_ANGLE;
                end
                ST_DIV_ANGLE: begin
                    if (i_div.done) begin
                        r_abs   <= i_div.quotient[ABS_W-1:0];
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_enc_last    <= e_ang;
                        r_enc_total   <= e_total;
                        r_enc_rounds  <= e_rounds;
                        r_out_target  <= TGT_ENCODER;
                        r_out_total   <= e_total;
                        r_out_rounds  <= e_rounds;
                        r_out_angle   <= ANGLE_NOW_W'(e_ang);
                        r_out_twice   <= '0;
                        r_out_current <= '0;
                        r_out_start   <= '0;
                        r_out_turns   <= e_turns[TURNS_W-1:0];
                        r_out_speed   <= e_sprod[SPD_W-1:0];
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_target            = r_out_target;
    assign o_total_angle       = $signed(r_out_total);
    assign o_round_count       = $signed(r_out_rounds);
    assign o_angle_now         = $signed(r_out_angle);
    assign o_speed_twice_avg   = $signed(r_out_twice);
    assign o_motor_current     = $signed(r_out_current);
    assign o_start_angle       = r_out_start;
    assign o_encoder_raw_turns = $signed(r_out_turns);
    assign o_angular_speed_q16 = r_out_speed;

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div.done |-> (r_state == ST_DIV_TURNS || r_state == ST_DIV_ANGLE))
        else $error("divider result outside a divide step");
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV_ANGLE && i_div.done) |->
            (i_div.quotient < DIV_W'(SCALE_COUNTS)))
        else $error("rescaled encoder angle out of range");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && out_free) |=>
            (r_out_valid && r_out_target == TGT_ENCODER && r_state == ST_IDLE))
        else $error("encoder result not loaded on finish");
`endif

endmodule

`default_nettype wire
